/* rtl/e2c_pkg.sv */
// e2c_pkg: constants and the month table for the epoch to calendar converter
// used by e2c_month_lookup and epoch_to_calendar_datetime; no dependencies
package e2c_pkg;

  localparam int unsigned NumStages = 8;

  localparam logic [31:0] Base2000Secs = 32'd946684800;
  localparam logic [31:0] End2100Secs  = 32'd4102444800;

  // reciprocals: x/60 = (x*R60)>>37, x/24 = (x*R24)>>36, x/1461 = (x*R1461)>>32
  localparam logic [31:0] Recip60   = 32'h88888889;
  localparam logic [31:0] Recip24   = 32'hAAAAAAAB;
  localparam logic [21:0] Recip1461 = 22'd2939745;

  localparam logic [10:0] DaysPerGroup = 11'd1461;
  localparam logic [10:0] Year1Start   = 11'd366;
  localparam logic [10:0] Year2Start   = 11'd731;
  localparam logic [10:0] Year3Start   = 11'd1096;

  // first day of each month within the year
  function automatic logic [8:0] month_first(input logic leap, input logic [3:0] mo);
    logic [8:0] base;
    case (mo)
      4'd0:    base = 9'd0;
      4'd1:    base = 9'd31;
      4'd2:    base = 9'd59;
      4'd3:    base = 9'd90;
      4'd4:    base = 9'd120;
      4'd5:    base = 9'd151;
      4'd6:    base = 9'd181;
      4'd7:    base = 9'd212;
      4'd8:    base = 9'd243;
      4'd9:    base = 9'd273;
      4'd10:   base = 9'd304;
      4'd11:   base = 9'd334;
      default: base = 9'd0;
    endcase
    if (leap && (mo >= 4'd2)) begin
      base = base + 9'd1;
    end
    return base;
  endfunction

endpackage

/* rtl/e2c_month_lookup.sv */
// e2c_month_lookup: day of year to month and day of month
// depends on e2c_pkg (month_first)
module e2c_month_lookup (
  input  logic [8:0] day_of_year_i,
  input  logic       leap_i,
  output logic [3:0] month_idx_o,
  output logic [4:0] day_idx_o
);

  logic [8:0] first;

  always_comb begin
    month_idx_o = 4'd0;
    for (int m = 1; m < 12; m++) begin
      if (day_of_year_i >= e2c_pkg::month_first(leap_i, 4'(m))) begin
        month_idx_o = 4'(m);
      end
    end
  end

  assign first     = e2c_pkg::month_first(leap_i, month_idx_o);
  assign day_idx_o = 5'(day_of_year_i - first);

endmodule

/* rtl/epoch_to_calendar_datetime.sv */
// epoch_to_calendar_datetime: top level of the epoch seconds to date/time converter
// depends on e2c_pkg and e2c_month_lookup
//
// Usage:
//   Input channel: epoch_seconds_i with in_valid_i / in_ready_o. A transaction
//   carries unsigned seconds since 1970-01-01 00:00:00.
//   Output channel: second, minute, hour, day, month, year of century and
//   out_of_range with out_valid_o / out_ready_i, one transaction per input.
//   Inputs before 2000-01-01 or from 2100-01-01 on give out_of_range = 1 and
//   all other fields zero.
//   Throughput is one transaction per cycle while out_ready_i is high: eight
//   register stages, each holding one constant-reciprocal multiply or a
//   subtract and a table compare, with a valid bit per stage.
//   Reset clears all stage valid bits; no transactions are in flight after it.
//   When the receiver stalls, a stage holds only while it is full and the one
//   after it cannot move, so bubbles close up; once all stages are full,
//   in_ready_o drops. Nothing is dropped or repeated.
module epoch_to_calendar_datetime (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] epoch_seconds_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [5:0]  sec_out_o,
  output logic [5:0]  min_out_o,
  output logic [4:0]  hour_out_o,
  output logic [4:0]  day_of_month_o,
  output logic [3:0]  month_out_o,
  output logic [6:0]  year_of_century_o,
  output logic        out_of_range_o
);

  localparam int unsigned NS = e2c_pkg::NumStages;

  logic [NS:1] valid_q;
  logic [NS:1] en;

  // stage payloads
  logic [NS-1:1] oor_q;
  logic [31:0]   rem1_q, rem2_q;
  logic [63:0]   p1_q;
  logic [25:0]   q1_q;
  logic [57:0]   p2_q;
  logic [19:0]   q2_q;
  logic [51:0]   p3_q;
  logic [15:0]   days_q;
  logic [37:0]   p4_q;
  logic [4:0]    grp6_q, grp7_q;
  logic [10:0]   dig_q;
  logic [1:0]    yr_q;
  logic [8:0]    doy_q;
  logic [5:0]    sec3_q, sec4_q, sec5_q, sec6_q, sec7_q;
  logic [5:0]    min4_q, min5_q, min6_q, min7_q;
  logic [4:0]    hour5_q, hour6_q, hour7_q;

  logic [5:0]    sec_q, min_q;
  logic [4:0]    hour_q, day_q;
  logic [3:0]    month_q;
  logic [6:0]    year_q;
  logic          oor_out_q;

  // combinational values between stages
  logic        oor_d;
  logic [25:0] q1_d;
  logic [19:0] q2_d;
  logic [15:0] days_d;
  logic [4:0]  grp_d;
  logic [10:0] dig_d;
  logic [1:0]  yr_d;
  logic [8:0]  doy_d;
  logic [3:0]  mo_idx;
  logic [4:0]  day_idx;

  // stall chain
  always_comb begin
    en[NS] = !valid_q[NS] || out_ready_i;
    for (int k = NS - 1; k >= 1; k--) begin
      en[k] = !valid_q[k] || en[k+1];
    end
  end

  assign in_ready_o = en[1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (en[1]) begin
        valid_q[1] <= in_valid_i;
      end
      for (int k = 2; k <= NS; k++) begin
        if (en[k]) begin
          valid_q[k] <= valid_q[k-1];
        end
      end
    end
  end

  assign oor_d  = (epoch_seconds_i < e2c_pkg::Base2000Secs) ||
                  (epoch_seconds_i >= e2c_pkg::End2100Secs);
  assign q1_d   = p1_q[62:37];
  assign q2_d   = p2_q[56:37];
  assign days_d = p3_q[51:36];
  assign grp_d  = p4_q[36:32];
  assign dig_d  = 11'(32'(days_q) - 32'(grp_d) * 32'(e2c_pkg::DaysPerGroup));

  // year within the four-year group, the first one leap
  always_comb begin
    if (dig_q < e2c_pkg::Year1Start) begin
      yr_d  = 2'd0;
      doy_d = 9'(dig_q);
    end else if (dig_q < e2c_pkg::Year2Start) begin
      yr_d  = 2'd1;
      doy_d = 9'(dig_q - e2c_pkg::Year1Start);
    end else if (dig_q < e2c_pkg::Year3Start) begin
      yr_d  = 2'd2;
      doy_d = 9'(dig_q - e2c_pkg::Year2Start);
    end else begin
      yr_d  = 2'd3;
      doy_d = 9'(dig_q - e2c_pkg::Year3Start);
    end
  end

  e2c_month_lookup u_month_lookup (
    .day_of_year_i (doy_q),
    .leap_i        (yr_q == 2'd0),
    .month_idx_o   (mo_idx),
    .day_idx_o     (day_idx)
  );

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      oor_q[1] <= oor_d;
      rem1_q   <= epoch_seconds_i - e2c_pkg::Base2000Secs;
    end
    if (en[2]) begin
      oor_q[2] <= oor_q[1];
      rem2_q   <= rem1_q;
      p1_q     <= 64'(rem1_q) * 64'(e2c_pkg::Recip60);
    end
    if (en[3]) begin
      oor_q[3] <= oor_q[2];
      q1_q     <= q1_d;
      sec3_q   <= 6'(rem2_q - 32'(q1_d) * 32'd60);
      p2_q     <= 58'(q1_d) * 58'(e2c_pkg::Recip60);
    end
    if (en[4]) begin
      oor_q[4] <= oor_q[3];
      q2_q     <= q2_d;
      sec4_q   <= sec3_q;
      min4_q   <= 6'(32'(q1_q) - 32'(q2_d) * 32'd60);
      p3_q     <= 52'(q2_d) * 52'(e2c_pkg::Recip24);
    end
    if (en[5]) begin
      oor_q[5] <= oor_q[4];
      days_q   <= days_d;
      sec5_q   <= sec4_q;
      min5_q   <= min4_q;
      hour5_q  <= 5'(32'(q2_q) - 32'(days_d) * 32'd24);
      p4_q     <= 38'(days_d) * 38'(e2c_pkg::Recip1461);
    end
    if (en[6]) begin
      oor_q[6] <= oor_q[5];
      grp6_q   <= grp_d;
      dig_q    <= dig_d;
      sec6_q   <= sec5_q;
      min6_q   <= min5_q;
      hour6_q  <= hour5_q;
    end
    if (en[7]) begin
      oor_q[7] <= oor_q[6];
      grp7_q   <= grp6_q;
      yr_q     <= yr_d;
      doy_q    <= doy_d;
      sec7_q   <= sec6_q;
      min7_q   <= min6_q;
      hour7_q  <= hour6_q;
    end
    if (en[8]) begin
      oor_out_q <= oor_q[7];
      if (oor_q[7]) begin
        sec_q   <= '0;
        min_q   <= '0;
        hour_q  <= '0;
        day_q   <= '0;
        month_q <= '0;
        year_q  <= '0;
      end else begin
        sec_q   <= sec7_q;
        min_q   <= min7_q;
        hour_q  <= hour7_q;
        day_q   <= day_idx + 5'd1;
        month_q <= mo_idx + 4'd1;
        year_q  <= {grp7_q, yr_q};
      end
    end
  end

  assign out_valid_o       = valid_q[NS];
  assign sec_out_o         = sec_q;
  assign min_out_o         = min_q;
  assign hour_out_o        = hour_q;
  assign day_of_month_o    = day_q;
  assign month_out_o       = month_q;
  assign year_of_century_o = year_q;
  assign out_of_range_o    = oor_out_q;

endmodule

/* tb/sv/tb.sv */
// tb: self-checking testbench for epoch_to_calendar_datetime, timestamps in, date and time out
// checks each output transaction against an in-file calendar predictor, with random stalls
// depends only on the epoch_to_calendar_datetime rtl
module tb;

  localparam logic [31:0] EpochOf2000 = 32'd946684800;
  localparam logic [31:0] EpochOf2100 = 32'd4102444800;
  localparam int unsigned SecsPerDay = 86400;
  localparam int unsigned RandomCount = 1700;

  typedef struct packed {
    logic [5:0] sec;
    logic [5:0] mins;
    logic [4:0] hours;
    logic [4:0] mday;
    logic [3:0] month;
    logic [6:0] year;
    logic       oor;
  } stamp_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] epoch = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [5:0]  sec_out;
  logic [5:0]  min_out;
  logic [4:0]  hour_out;
  logic [4:0]  day_of_month;
  logic [3:0]  month_out;
  logic [6:0]  year_of_century;
  logic        out_of_range;

  logic [31:0] pending_epochs[$];
  stamp_t      due_stamps[$];
  int unsigned sent_count = 0;
  int unsigned oor_count = 0;
  int unsigned checked_count = 0;
  int unsigned error_count = 0;
  int unsigned hold_left = 0;
  logic        hold_done = 1'b0;

  epoch_to_calendar_datetime i_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid),
    .in_ready_o        (in_ready),
    .epoch_seconds_i   (epoch),
    .out_valid_o       (out_valid),
    .out_ready_i       (out_ready),
    .sec_out_o         (sec_out),
    .min_out_o         (min_out),
    .hour_out_o        (hour_out),
    .day_of_month_o    (day_of_month),
    .month_out_o       (month_out),
    .year_of_century_o (year_of_century),
    .out_of_range_o    (out_of_range)
  );

  always #1 clk_i = ~clk_i;

  function automatic int unsigned month_len(input int unsigned mo, input logic leap);
    case (mo)
      1:           return leap ? 29 : 28;
      3, 5, 8, 10: return 30;
      default:     return 31;
    endcase
  endfunction

  function automatic stamp_t calendar_of(input logic [31:0] secs);
    stamp_t      r;
    int unsigned rest, days, group, dig, yr, mo;
    r = '0;
    if (secs < EpochOf2000 || secs >= EpochOf2100) begin
      r.oor = 1'b1;
      return r;
    end
    rest = secs - EpochOf2000;
    r.sec = 6'(rest % 60);
    rest = rest / 60;
    r.mins = 6'(rest % 60);
    rest = rest / 60;
    r.hours = 5'(rest % 24);
    days = rest / 24;
    group = days / 1461;
    dig = days % 1461;
    if (dig >= 1096) begin
      yr = 3;
      dig = dig - 1096;
    end else if (dig >= 731) begin
      yr = 2;
      dig = dig - 731;
    end else if (dig >= 366) begin
      yr = 1;
      dig = dig - 366;
    end else begin
      yr = 0;
    end
    mo = 0;
    while (dig >= month_len(mo, yr == 0)) begin
      dig = dig - month_len(mo, yr == 0);
      mo++;
    end
    r.mday = 5'(dig + 1);
    r.month = 4'(mo + 1);
    r.year = 7'(group * 4 + yr);
    return r;
  endfunction

  // yr counts from 2000, doy and sod are zero based
  function automatic logic [31:0] seconds_at(input int unsigned yr, input int unsigned doy,
                                             input int unsigned sod);
    return EpochOf2000 + (yr * 365 + (yr + 3) / 4 + doy) * SecsPerDay + sod;
  endfunction

  function automatic logic [31:0] random_epoch();
    int unsigned pick, yr, last_doy, doy, sod;
    pick = $urandom_range(0, 99);
    yr = $urandom_range(0, 99);
    last_doy = (yr % 4 == 0) ? 365 : 364;
    doy = $urandom_range(0, last_doy);
    sod = $urandom_range(0, SecsPerDay - 1);
    if (pick < 40) begin
      return $urandom();
    end else if (pick < 75) begin
      return seconds_at(yr, doy, sod);
    end else if (pick < 90) begin
      case ($urandom_range(0, 5))
        0: doy = 0;
        1: doy = 58;
        2: doy = 59;
        3: doy = 60;
        4: doy = last_doy;
        default: ;
      endcase
      return seconds_at(yr, doy, $urandom_range(0, 1) ? SecsPerDay - 1 : 0);
    end else if (pick < 95) begin
      return EpochOf2000 + $urandom_range(0, 200) - 100;
    end else begin
      return EpochOf2100 + $urandom_range(0, 200) - 100;
    end
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("mismatch on %s at result %0d: got %0d, expected %0d",
             what, checked_count, got, want);
    error_count++;
  endtask

  // sender
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      epoch <= '0;
    end else begin
      if (in_valid && in_ready) begin
        due_stamps.push_back(calendar_of(epoch));
        if (calendar_of(epoch).oor) begin
          oor_count++;
        end
        sent_count++;
      end
      if (!in_valid || in_ready) begin
        if (pending_epochs.size() != 0 &&
            ((sent_count >= 900 && sent_count < 1200) || $urandom_range(0, 99) >= 32)) begin
          in_valid <= 1'b1;
          epoch <= pending_epochs.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off so the pipeline fills and back-pressures the input
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && checked_count >= 400) begin
      hold_left <= 80;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // receiver and checker
  always @(posedge clk_i or negedge rst_ni) begin
    stamp_t want;
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (due_stamps.size() == 0) begin
          report_mismatch("unexpected transaction", 1, 0);
        end else begin
          want = due_stamps.pop_front();
          if (sec_out !== want.sec) begin
            report_mismatch("sec_out", 32'(sec_out), 32'(want.sec));
          end
          if (min_out !== want.mins) begin
            report_mismatch("min_out", 32'(min_out), 32'(want.mins));
          end
          if (hour_out !== want.hours) begin
            report_mismatch("hour_out", 32'(hour_out), 32'(want.hours));
          end
          if (day_of_month !== want.mday) begin
            report_mismatch("day_of_month", 32'(day_of_month), 32'(want.mday));
          end
          if (month_out !== want.month) begin
            report_mismatch("month_out", 32'(month_out), 32'(want.month));
          end
          if (year_of_century !== want.year) begin
            report_mismatch("year_of_century", 32'(year_of_century), 32'(want.year));
          end
          if (out_of_range !== want.oor) begin
            report_mismatch("out_of_range", 32'(out_of_range), 32'(want.oor));
          end
        end
        checked_count++;
      end
      out_ready <= (hold_left == 0) &&
                   ((checked_count >= 900 && checked_count < 1200) ||
                    $urandom_range(0, 99) >= 32);
    end
  end

  initial begin
    // range edges, leap days, year ends and the 32-bit extremes
    pending_epochs.push_back(32'd0);
    pending_epochs.push_back(32'hFFFF_FFFF);
    pending_epochs.push_back(EpochOf2000 - 1);
    pending_epochs.push_back(EpochOf2000);
    pending_epochs.push_back(EpochOf2100 - 1);
    pending_epochs.push_back(EpochOf2100);
    pending_epochs.push_back(32'h7FFF_FFFF);
    pending_epochs.push_back(32'h8000_0000);
    pending_epochs.push_back(seconds_at(0, 58, SecsPerDay - 1));
    pending_epochs.push_back(seconds_at(0, 59, 45296));
    pending_epochs.push_back(seconds_at(0, 60, 0));
    pending_epochs.push_back(seconds_at(0, 365, SecsPerDay - 1));
    pending_epochs.push_back(seconds_at(1, 0, 0));
    pending_epochs.push_back(seconds_at(1, 58, SecsPerDay - 1));
    pending_epochs.push_back(seconds_at(1, 59, 0));
    pending_epochs.push_back(seconds_at(3, 364, SecsPerDay - 1));
    pending_epochs.push_back(seconds_at(4, 0, 0));
    pending_epochs.push_back(seconds_at(4, 59, 3599));
    pending_epochs.push_back(seconds_at(96, 59, 43200));
    pending_epochs.push_back(seconds_at(99, 58, SecsPerDay - 1));
    pending_epochs.push_back(seconds_at(99, 59, 0));
    pending_epochs.push_back(seconds_at(50, 180, 59));
    for (int i = 0; i < RandomCount; i++) begin
      pending_epochs.push_back(random_epoch());
    end
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (pending_epochs.size() != 0 || in_valid) @(posedge clk_i);
    while (due_stamps.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
    $display("summary: %0d timestamps converted, %0d outside 2000-2099, %0d results compared",
             sent_count, oor_count, checked_count);
    $display("summary: leap days, month and year rollovers, range edges, long output stall");
    if (error_count == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("tb: errors");
    $finish;
  end

endmodule

/* files.f */
rtl/e2c_pkg.sv
rtl/e2c_month_lookup.sv
rtl/epoch_to_calendar_datetime.sv
tb/sv/tb.sv
